// ===== design/hlf_pkg.sv =====
// hlf_pkg: shared types, codes and defaults of the http/1 head line framer
package hlf_pkg;

  localparam int FIELD_W     = 21;
  localparam int LIM_W       = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 4;
  localparam int OFFSET_BITS_DEF = 21;

  localparam logic [FIELD_W-1:0] MAX_HEAD_DEF   = FIELD_W'(65536);
  localparam logic [LIM_W-1:0]   MAX_START_DEF  = LIM_W'(8192);
  localparam logic [LIM_W-1:0]   MAX_FIELD_DEF  = LIM_W'(8192);

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [1:0] ST_MORE  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_HEAD_SIZE  = 3'd1;
  localparam logic [2:0] ERR_LINE_END   = 3'd2;
  localparam logic [2:0] ERR_START_LONG = 3'd3;
  localparam logic [2:0] ERR_FIELD_LONG = 3'd4;

  localparam logic [1:0] REG_MAX_HEAD  = 2'd0;
  localparam logic [1:0] REG_MAX_START = 2'd1;
  localparam logic [1:0] REG_MAX_FIELD = 2'd2;

  typedef enum logic [2:0] {
    PH_RUN  = 3'b001,
    PH_DONE = 3'b010,
    PH_ERR  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [FIELD_W-1:0] max_head;
    logic [LIM_W-1:0]   max_start_line;
    logic [LIM_W-1:0]   max_field_line;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         error_code;
    logic [FIELD_W-1:0] error_offset;
    logic [FIELD_W-1:0] error_line;
    logic [FIELD_W-1:0] head_bytes;
  } res_t;

endpackage

// ===== design/hlf_cfg.sv =====
// hlf_cfg: apb register file holding the head and line limits
module hlf_cfg
  import hlf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_head       <= MAX_HEAD_DEF;
      cfg.max_start_line <= MAX_START_DEF;
      cfg.max_field_line <= MAX_FIELD_DEF;
    end else if (wr) begin
      unique case (idx)
        REG_MAX_HEAD:  cfg.max_head       <= pwdata[FIELD_W-1:0];
        REG_MAX_START: cfg.max_start_line <= pwdata[LIM_W-1:0];
        REG_MAX_FIELD: cfg.max_field_line <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_HEAD:  prdata = CFG_DATA_W'(cfg.max_head);
      REG_MAX_START: prdata = CFG_DATA_W'(cfg.max_start_line);
      REG_MAX_FIELD: prdata = CFG_DATA_W'(cfg.max_field_line);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== design/hlf_core.sv =====
// hlf_core: framing state and the single-pass byte check
module hlf_core
  import hlf_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic       op,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output res_t       res
);

  localparam int W  = OFFSET_BITS;
  localparam int CW = ((W > FIELD_W) ? W : FIELD_W) + 1;
  localparam int LW = (W > LIM_W) ? W : LIM_W;

  logic [W-1:0]       byte_offset, byte_offset_next;
  logic [W-1:0]       line_start, line_start_next;
  logic [W-1:0]       line_number, line_number_next;
  logic               cr_pending, cr_pending_next;
  phase_t             phase, phase_next;
  logic [2:0]         held_code, held_code_next;
  logic [FIELD_W-1:0] held_offset, held_offset_next;
  logic [FIELD_W-1:0] held_line, held_line_next;

  logic               first_line;
  logic [LIM_W-1:0]   limit;
  logic [2:0]         long_code;
  logic [W-1:0]       cr_at, len, pos, i_inc, ln_inc;
  logic [W:0]         total;
  logic               len_over, len_zero, total_over, i_big, pos_over;
  logic [CW-1:0]      ext_i, ext_cr, ext_ls, ext_ln, ext_tot, ext_mh;
  logic [FIELD_W-1:0] fld_i, fld_cr, fld_ls, fld_ln, fld_tot;
  logic               fail;
  logic [2:0]         fail_code;
  logic [FIELD_W-1:0] fail_off, fail_line;

  assign first_line = (line_number == W'(1));
  assign limit      = first_line ? cfg.max_start_line : cfg.max_field_line;
  assign long_code  = first_line ? ERR_START_LONG : ERR_FIELD_LONG;

  assign cr_at    = (byte_offset != '0) ? byte_offset - W'(1) : '0;
  assign len      = (cr_at >= line_start) ? cr_at - line_start : '0;
  assign len_over = LW'(len) > LW'(limit);
  assign len_zero = (len == '0);
  assign total    = {1'b0, cr_at} + (W+1)'(2);

  assign ext_i   = CW'(byte_offset);
  assign ext_cr  = CW'(cr_at);
  assign ext_ls  = CW'(line_start);
  assign ext_ln  = CW'(line_number);
  assign ext_tot = CW'(total);
  assign ext_mh  = CW'(cfg.max_head);
  assign fld_i   = ext_i[FIELD_W-1:0];
  assign fld_cr  = ext_cr[FIELD_W-1:0];
  assign fld_ls  = ext_ls[FIELD_W-1:0];
  assign fld_ln  = ext_ln[FIELD_W-1:0];
  assign fld_tot = ext_tot[FIELD_W-1:0];

  assign total_over = ext_tot > ext_mh;
  assign i_big      = (ext_i >= ext_mh) || (&byte_offset);
  assign pos        = (byte_offset >= line_start) ? byte_offset - line_start : '0;
  assign pos_over   = LW'(pos) >= LW'(limit);
  assign i_inc      = (&byte_offset) ? byte_offset : byte_offset + W'(1);
  assign ln_inc     = (&line_number) ? line_number : line_number + W'(1);

  always_comb begin
    byte_offset_next = byte_offset;
    line_start_next  = line_start;
    line_number_next = line_number;
    cr_pending_next  = cr_pending;
    phase_next       = phase;
    held_code_next   = held_code;
    held_offset_next = held_offset;
    held_line_next   = held_line;
    res              = '0;
    res.status       = ST_MORE;
    fail             = 1'b0;
    fail_code        = ERR_NONE;
    fail_off         = '0;
    fail_line        = '0;

    priority if (op == OP_RESTART) begin
      byte_offset_next = '0;
      line_start_next  = '0;
      line_number_next = W'(1);
      cr_pending_next  = 1'b0;
      phase_next       = PH_RUN;
      held_code_next   = ERR_NONE;
      held_offset_next = '0;
      held_line_next   = '0;
    end else if (phase == PH_DONE) begin
      res.status     = ST_DONE;
      res.head_bytes = fld_i;
    end else if (phase == PH_ERR) begin
      res.status       = ST_ERROR;
      res.error_code   = held_code;
      res.error_offset = held_offset;
      res.error_line   = held_line;
    end else if (cr_pending) begin
      cr_pending_next = 1'b0;
      priority if (data_byte != CH_LF) begin
        fail      = 1'b1;
        fail_code = ERR_LINE_END;
        fail_off  = fld_cr;
        fail_line = fld_ln;
      end else if (len_over) begin
        fail      = 1'b1;
        fail_code = long_code;
        fail_off  = fld_ls;
        fail_line = fld_ln;
      end else if (!first_line && len_zero) begin
        if (total_over) begin
          fail      = 1'b1;
          fail_code = ERR_HEAD_SIZE;
        end else begin
          byte_offset_next = i_inc;
          phase_next       = PH_DONE;
          res.status       = ST_DONE;
          res.head_bytes   = fld_tot;
        end
      end else begin
        byte_offset_next = i_inc;
        line_start_next  = i_inc;
        line_number_next = ln_inc;
      end
    end else if (i_big) begin
      fail      = 1'b1;
      fail_code = ERR_HEAD_SIZE;
    end else if (data_byte == CH_LF) begin
      fail      = 1'b1;
      fail_code = ERR_LINE_END;
      fail_off  = fld_i;
      fail_line = fld_ln;
    end else if (data_byte == CH_CR) begin
      cr_pending_next  = 1'b1;
      byte_offset_next = i_inc;
    end else if (pos_over) begin
      fail      = 1'b1;
      fail_code = long_code;
      fail_off  = fld_ls;
      fail_line = fld_ln;
    end else begin
      byte_offset_next = i_inc;
    end

    if (fail) begin
      phase_next       = PH_ERR;
      held_code_next   = fail_code;
      held_offset_next = fail_off;
      held_line_next   = fail_line;
      res.status       = ST_ERROR;
      res.error_code   = fail_code;
      res.error_offset = fail_off;
      res.error_line   = fail_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      line_start  <= '0;
      line_number <= W'(1);
      cr_pending  <= 1'b0;
      phase       <= PH_RUN;
      held_code   <= ERR_NONE;
      held_offset <= '0;
      held_line   <= '0;
    end else if (go) begin
      byte_offset <= byte_offset_next;
      line_start  <= line_start_next;
      line_number <= line_number_next;
      cr_pending  <= cr_pending_next;
      phase       <= phase_next;
      held_code   <= held_code_next;
      held_offset <= held_offset_next;
      held_line   <= held_line_next;
    end
  end

endmodule

// ===== design/http1_head_line_framer.sv =====
// http1_head_line_framer: top level with input register, framing core and result register
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | op, data_byte
//   out     | output    | out_valid / out_stall| status, error_code, error_offset,
//           |           |                      | error_line, head_bytes
//   cfg     | input     | apb psel/penable     | paddr, pwdata, prdata
//
// one word per cycle while out_stall is low; results come from the result register
// the byte check and state update are combinational between the input and result registers
// reset clears the framing state and both valid flags; limits return to their defaults
// out_stall holds the result word; one further word is taken into the input register
module http1_head_line_framer
  import hlf_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [7:0]            data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [2:0]            error_code,
  output logic [FIELD_W-1:0]    error_offset,
  output logic [FIELD_W-1:0]    error_line,
  output logic [FIELD_W-1:0]    head_bytes,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  res_t       res;
  res_t       res_q;
  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_byte;
  logic       adv;
  logic       go;

  hlf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hlf_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .op        (s1_op),
    .data_byte (s1_byte),
    .cfg       (cfg),
    .res       (res)
  );

  assign adv      = ~out_valid | ~out_stall;
  assign go       = s1_valid & adv;
  assign in_stall = s1_valid & ~adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op   <= op;
      s1_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_q <= res;
    end
  end

  assign status       = res_q.status;
  assign error_code   = res_q.error_code;
  assign error_offset = res_q.error_offset;
  assign error_line   = res_q.error_line;
  assign head_bytes   = res_q.head_bytes;

endmodule

// ===== design/hlf_checker.sv =====
// hlf_checker: port-level assertions for the head line framer, bound to the top level
module hlf_checker
  import hlf_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         status,
  input logic [2:0]         error_code,
  input logic [FIELD_W-1:0] error_offset,
  input logic [FIELD_W-1:0] error_line,
  input logic [FIELD_W-1:0] head_bytes
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(error_code)
      && $stable(error_offset) && $stable(error_line) && $stable(head_bytes))
    else $error("stalled result word changed");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DONE |->
      error_code == ERR_NONE && error_offset == '0 && error_line == '0)
    else $error("completed head carries error fields");

  a_error_coded: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ERROR |-> error_code != ERR_NONE && head_bytes == '0)
    else $error("error word without code or with head length");

  a_more_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_MORE |-> error_code == ERR_NONE && head_bytes == '0)
    else $error("pending word carries result fields");

endmodule

bind http1_head_line_framer hlf_checker u_hlf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .error_code   (error_code),
  .error_offset (error_offset),
  .error_line   (error_line),
  .head_bytes   (head_bytes)
);
